/* rtl/snmprh_pkg.sv */
// ----------------------------------------------------------------------------
// SNMP response header parser package
// Shared constants and the result word type of the header parser.
// ----------------------------------------------------------------------------
package snmprh_pkg;

    localparam int MAX_PACKET_BYTES  = 65535;
    localparam int MAX_INTEGER_BYTES = 20;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 224;

    localparam logic [7:0]  TAG_SEQUENCE  = 8'h30;
    localparam logic [7:0]  TAG_INTEGER   = 8'h02;
    localparam logic [7:0]  TAG_OCTETS    = 8'h04;
    localparam logic [7:0]  TAG_PDU_LO    = 8'hA0;
    localparam logic [7:0]  TAG_PDU_HI    = 8'hA5;
    localparam logic [24:0] LENGTH_MAX    = 25'h10000;
    localparam logic [16:0] LIMIT_NONE    = 17'h1FFFF;

    typedef struct packed {
        logic        verdict;
        logic [15:0] varbinds_end;
        logic [15:0] varbinds_offset;
        logic [7:0]  pdu_type;
        logic [16:0] comm_bytes;
        logic [63:0] err_idx;
        logic [63:0] err_stat;
        logic [31:0] rsp_id;
    } result_t;

endpackage

/* rtl/snmprh_core.sv */
// ----------------------------------------------------------------------------
// SNMP response header parser core
// Walks the BER header one byte per cycle while accept is high and forms the
// verdict word on the last byte of a packet.
// ----------------------------------------------------------------------------
module snmprh_core
    import snmprh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    input  logic [30:0]   expected_id,
    output logic          res_valid,
    output result_t       res
);

    localparam logic [3:0] PH_OUTER_TAG = 4'd0;
    localparam logic [3:0] PH_OUTER_LEN = 4'd1;
    localparam logic [3:0] PH_INT_TAG   = 4'd2;
    localparam logic [3:0] PH_INT_LEN   = 4'd3;
    localparam logic [3:0] PH_INT_BODY  = 4'd4;
    localparam logic [3:0] PH_COMM_TAG  = 4'd5;
    localparam logic [3:0] PH_COMM_LEN  = 4'd6;
    localparam logic [3:0] PH_COMM_SKIP = 4'd7;
    localparam logic [3:0] PH_PDU_TAG   = 4'd8;
    localparam logic [3:0] PH_PDU_LEN   = 4'd9;
    localparam logic [3:0] PH_VB_TAG    = 4'd10;
    localparam logic [3:0] PH_VB_LEN    = 4'd11;
    localparam logic [3:0] PH_DONE      = 4'd12;

    localparam logic [1:0] SITE_VERSION = 2'd0;
    localparam logic [1:0] SITE_REQ_ID  = 2'd1;
    localparam logic [1:0] SITE_STATUS  = 2'd2;
    localparam logic [1:0] SITE_INDEX   = 2'd3;

    logic [3:0]  phase_reg,     phase_next;
    logic [15:0] offset_reg,    offset_next;
    logic [16:0] limit_reg,     limit_next;
    logic [16:0] laccum_reg,    laccum_next;
    logic [6:0]  lleft_reg,     lleft_next;
    logic [63:0] iaccum_reg,    iaccum_next;
    logic [4:0]  ileft_reg,     ileft_next;
    logic [16:0] skip_reg,      skip_next;
    logic [31:0] rid_reg,       rid_next;
    logic [63:0] status_reg,    status_next;
    logic [63:0] index_reg,     index_next;
    logic [16:0] comm_reg,      comm_next;
    logic [7:0]  pdu_reg,       pdu_next;
    logic [15:0] vb_off_reg,    vb_off_next;
    logic [15:0] vb_lim_reg,    vb_lim_next;
    logic        rejected_reg,  rejected_next;
    logic [1:0]  site_reg,      site_next;

    logic [24:0] len_wide;
    logic [16:0] len_accum_upd;
    logic [6:0]  len_left_upd;
    logic        len_done;
    logic        len_bad;
    logic [16:0] pos_inc;
    logic [17:0] len_end;
    logic [16:0] narrowed;
    logic [15:0] narrowed_clip;
    logic        finish;
    logic        clear;

    assign pos_inc  = {1'b0, offset_reg} + 17'd1;
    assign len_wide = {laccum_reg, data_byte};

    always_comb
    begin
        len_accum_upd = laccum_reg;
        len_left_upd  = lleft_reg;
        len_done      = 1'b0;
        len_bad       = 1'b0;
        if (lleft_reg == 7'd0)
        begin
            if (data_byte[7])
            begin
                if (data_byte[6:0] == 7'd0)
                begin
                    len_bad = 1'b1;
                end
                else
                begin
                    len_left_upd  = data_byte[6:0];
                    len_accum_upd = '0;
                end
            end
            else
            begin
                len_accum_upd = {9'd0, data_byte};
                len_done      = 1'b1;
            end
        end
        else
        begin
            if (len_wide > LENGTH_MAX)
            begin
                len_bad = 1'b1;
            end
            else
            begin
                len_accum_upd = len_wide[16:0];
                len_left_upd  = lleft_reg - 7'd1;
                len_done      = (len_left_upd == 7'd0);
            end
        end
    end

    assign len_end       = {1'b0, pos_inc} + {1'b0, len_accum_upd};
    assign narrowed      = (len_end < {1'b0, limit_reg}) ? len_end[16:0] : limit_reg;
    assign narrowed_clip = narrowed[16] ? 16'hFFFF : narrowed[15:0];

    always_comb
    begin
        phase_next    = phase_reg;
        offset_next   = offset_reg;
        limit_next    = limit_reg;
        laccum_next   = laccum_reg;
        lleft_next    = lleft_reg;
        iaccum_next   = iaccum_reg;
        ileft_next    = ileft_reg;
        skip_next     = skip_reg;
        rid_next      = rid_reg;
        status_next   = status_reg;
        index_next    = index_reg;
        comm_next     = comm_reg;
        pdu_next      = pdu_reg;
        vb_off_next   = vb_off_reg;
        vb_lim_next   = vb_lim_reg;
        rejected_next = rejected_reg;
        site_next     = site_reg;
        finish        = 1'b0;

        if (accept)
        begin
            if ({1'b0, offset_reg} >= 17'(MAX_PACKET_BYTES))
            begin
                rejected_next = 1'b1;
            end
            if (!rejected_next && phase_reg != PH_DONE)
            begin
                if ({1'b0, offset_reg} >= limit_reg)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_OUTER_TAG, PH_VB_TAG:
                        begin
                            if (data_byte != TAG_SEQUENCE)
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                lleft_next = '0;
                                phase_next = (phase_reg == PH_OUTER_TAG) ? PH_OUTER_LEN
                                                                         : PH_VB_LEN;
                            end
                        end
                        PH_INT_TAG:
                        begin
                            if (data_byte != TAG_INTEGER)
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                lleft_next = '0;
                                phase_next = PH_INT_LEN;
                            end
                        end
                        PH_COMM_TAG:
                        begin
                            if (data_byte != TAG_OCTETS)
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                lleft_next = '0;
                                phase_next = PH_COMM_LEN;
                            end
                        end
                        PH_PDU_TAG:
                        begin
                            if (data_byte < TAG_PDU_LO || data_byte > TAG_PDU_HI)
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                pdu_next   = data_byte;
                                lleft_next = '0;
                                phase_next = PH_PDU_LEN;
                            end
                        end
                        PH_INT_BODY:
                        begin
                            iaccum_next = {iaccum_reg[55:0], data_byte};
                            ileft_next  = ileft_reg - 5'd1;
                            finish      = (ileft_next == 5'd0);
                        end
                        PH_COMM_SKIP:
                        begin
                            skip_next = skip_reg - 17'd1;
                            if (skip_next == 17'd0)
                            begin
                                phase_next = PH_PDU_TAG;
                            end
                        end
                        PH_OUTER_LEN, PH_PDU_LEN, PH_COMM_LEN, PH_INT_LEN, PH_VB_LEN:
                        begin
                            if (len_bad)
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                laccum_next = len_accum_upd;
                                lleft_next  = len_left_upd;
                                if (len_done)
                                begin
                                    unique case (phase_reg)
                                        PH_OUTER_LEN:
                                        begin
                                            limit_next = narrowed;
                                            site_next  = SITE_VERSION;
                                            phase_next = PH_INT_TAG;
                                        end
                                        PH_PDU_LEN:
                                        begin
                                            limit_next = narrowed;
                                            site_next  = SITE_REQ_ID;
                                            phase_next = PH_INT_TAG;
                                        end
                                        PH_COMM_LEN:
                                        begin
                                            comm_next  = len_accum_upd;
                                            skip_next  = len_accum_upd;
                                            phase_next = (len_accum_upd == 17'd0) ? PH_PDU_TAG
                                                                                  : PH_COMM_SKIP;
                                        end
                                        PH_INT_LEN:
                                        begin
                                            if (len_accum_upd > 17'(MAX_INTEGER_BYTES))
                                            begin
                                                rejected_next = 1'b1;
                                            end
                                            else
                                            begin
                                                iaccum_next = '0;
                                                ileft_next  = len_accum_upd[4:0];
                                                if (len_accum_upd == 17'd0)
                                                begin
                                                    finish = 1'b1;
                                                end
                                                else
                                                begin
                                                    phase_next = PH_INT_BODY;
                                                end
                                            end
                                        end
                                        default:
                                        begin
                                            limit_next  = narrowed;
                                            vb_off_next = pos_inc[15:0];
                                            vb_lim_next = narrowed_clip;
                                            phase_next  = PH_DONE;
                                        end
                                    endcase
                                end
                            end
                        end
                        default:
                        begin
                            rejected_next = 1'b1;
                        end
                    endcase

                    if (finish)
                    begin
                        unique case (site_reg)
                            SITE_VERSION:
                            begin
                                if (iaccum_next != 64'd0)
                                begin
                                    rejected_next = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_COMM_TAG;
                                end
                            end
                            SITE_REQ_ID:
                            begin
                                rid_next = iaccum_next[31:0];
                                if (iaccum_next[31:0] != {1'b0, expected_id})
                                begin
                                    rejected_next = 1'b1;
                                end
                                else
                                begin
                                    site_next  = SITE_STATUS;
                                    phase_next = PH_INT_TAG;
                                end
                            end
                            SITE_STATUS:
                            begin
                                status_next = iaccum_next;
                                site_next   = SITE_INDEX;
                                phase_next  = PH_INT_TAG;
                            end
                            default:
                            begin
                                index_next = iaccum_next;
                                phase_next = PH_VB_TAG;
                            end
                        endcase
                    end
                end
            end
            offset_next = (offset_reg == 16'hFFFF) ? offset_reg : pos_inc[15:0];
        end
    end

    assign clear     = accept && last_byte;
    assign res_valid = clear;

    always_comb
    begin
        res = '0;
        if (!rejected_next && phase_next == PH_DONE)
        begin
            res.rsp_id          = rid_next;
            res.err_stat        = status_next;
            res.err_idx         = index_next;
            res.comm_bytes      = comm_next;
            res.pdu_type        = pdu_next;
            res.varbinds_offset = vb_off_next;
            res.varbinds_end    = ({1'b0, vb_lim_next} < pos_inc) ? vb_lim_next
                                                                  : pos_inc[15:0];
        end
        else
        begin
            res.verdict = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_OUTER_TAG;
            offset_reg   <= '0;
            limit_reg    <= LIMIT_NONE;
            laccum_reg   <= '0;
            lleft_reg    <= '0;
            iaccum_reg   <= '0;
            ileft_reg    <= '0;
            skip_reg     <= '0;
            rid_reg      <= '0;
            status_reg   <= '0;
            index_reg    <= '0;
            comm_reg     <= '0;
            pdu_reg      <= '0;
            vb_off_reg   <= '0;
            vb_lim_reg   <= '0;
            rejected_reg <= 1'b0;
            site_reg     <= SITE_VERSION;
        end
        else if (clear)
        begin
            phase_reg    <= PH_OUTER_TAG;
            offset_reg   <= '0;
            limit_reg    <= LIMIT_NONE;
            laccum_reg   <= '0;
            lleft_reg    <= '0;
            iaccum_reg   <= '0;
            ileft_reg    <= '0;
            skip_reg     <= '0;
            rid_reg      <= '0;
            status_reg   <= '0;
            index_reg    <= '0;
            comm_reg     <= '0;
            pdu_reg      <= '0;
            vb_off_reg   <= '0;
            vb_lim_reg   <= '0;
            rejected_reg <= 1'b0;
            site_reg     <= SITE_VERSION;
        end
        else
        begin
            phase_reg    <= phase_next;
            offset_reg   <= offset_next;
            limit_reg    <= limit_next;
            laccum_reg   <= laccum_next;
            lleft_reg    <= lleft_next;
            iaccum_reg   <= iaccum_next;
            ileft_reg    <= ileft_next;
            skip_reg     <= skip_next;
            rid_reg      <= rid_next;
            status_reg   <= status_next;
            index_reg    <= index_next;
            comm_reg     <= comm_next;
            pdu_reg      <= pdu_next;
            vb_off_reg   <= vb_off_next;
            vb_lim_reg   <= vb_lim_next;
            rejected_reg <= rejected_next;
            site_reg     <= site_next;
        end
    end

endmodule

/* rtl/snmp_response_header_parser.sv */
// ----------------------------------------------------------------------------
// SNMP response header parser
// Checks the BER header of an SNMP response, one payload byte per word, and
// delivers one verdict word with the extracted header fields per packet.
// ----------------------------------------------------------------------------
// Channel   Direction  Word contents
// s_axis    in         tdata: data_byte, expected_id; tlast: last_byte
// m_axis    out        tdata: header fields; tuser: verdict
//
// One input word is taken every cycle while s_tready is high; the parser
// state is updated in the same cycle through a single level of byte decode
// logic. A verdict word passes through the output register, or first the skid
// register while the output register holds one, to the master side. The two
// let input flow on while a verdict waits; input stalls only when both hold a
// verdict. Reset clears the parser to the start of a packet and empties both.
// ----------------------------------------------------------------------------
module snmp_response_header_parser
    import snmprh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // data_byte[7:0], expected_id[38:8], zero
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // rsp_id, err_stat, err_idx,
                                              // comm_bytes, pdu_type,
                                              // varbinds_offset, varbinds_end, zero
    output logic                   m_tuser    // verdict
);

    logic    accept;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;
    logic    out_take;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;

    snmprh_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (s_tdata[7:0]),
        .last_byte   (s_tlast),
        .expected_id (s_tdata[38:8]),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (res_valid)
            begin
                out_reg <= res;
            end
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.verdict;
    assign m_tdata  = {7'd0, out_reg.varbinds_end, out_reg.varbinds_offset,
                       out_reg.pdu_type, out_reg.comm_bytes,
                       out_reg.err_idx, out_reg.err_stat, out_reg.rsp_id};

endmodule

/* rtl/snmprh_checker.sv */
// ----------------------------------------------------------------------------
// SNMP response header parser checker
// Port-level properties of the header parser, bound to the top level.
// ----------------------------------------------------------------------------
module snmprh_checker
    import snmprh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tuser
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("verdict word withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("verdict word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("rejected verdict carries field data");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
    else $error("verdict word without a preceding last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[216:201] >= m_tdata[200:185])
    else $error("varbind end lies before varbind offset");

endmodule

bind snmp_response_header_parser snmprh_checker u_snmprh_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// SNMP response header parser testbench
// Streams SNMP response packets through the parser, one byte per word, with
// bursty input and a receiver that stalls, and checks every verdict word
// against a byte-level model of the BER header walk kept in a scoreboard.
// ----------------------------------------------------------------------------
module testbench;

    import snmprh_pkg::*;

    localparam int HOLD_CYCLES = 500;
    localparam int STALL_LIMIT = 3000;

    typedef enum logic [3:0] {
        P_OUTER_TAG,
        P_OUTER_LEN,
        P_INT_TAG,
        P_INT_LEN,
        P_INT_BODY,
        P_COMM_TAG,
        P_COMM_LEN,
        P_COMM_SKIP,
        P_PDU_TAG,
        P_PDU_LEN,
        P_VB_TAG,
        P_VB_LEN,
        P_DONE
    } phase_e;

    typedef enum logic [1:0] {
        SITE_VERSION,
        SITE_REQ_ID,
        SITE_STATUS,
        SITE_INDEX
    } site_e;

    typedef enum logic [1:0] {
        LEN_MORE,
        LEN_DONE,
        LEN_BAD
    } len_step_e;

    class snmp_header_scoreboard;
        phase_e      phase;
        site_e       site;
        int unsigned offset;
        int unsigned limit;
        int unsigned len_acc;
        int unsigned len_left;
        int unsigned int_left;
        int unsigned skip_left;
        logic [63:0] int_acc;
        logic [31:0] req_id;
        logic [63:0] err_status;
        logic [63:0] err_index;
        logic [16:0] comm_len;
        logic [7:0]  pdu_tag;
        logic [15:0] vb_offset;
        logic [15:0] vb_limit;
        bit          rejected;
        result_t     verdicts_due[$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase      = P_OUTER_TAG;
            site       = SITE_VERSION;
            offset     = 0;
            limit      = LIMIT_NONE;
            len_acc    = 0;
            len_left   = 0;
            int_left   = 0;
            skip_left  = 0;
            int_acc    = '0;
            req_id     = '0;
            err_status = '0;
            err_index  = '0;
            comm_len   = '0;
            pdu_tag    = '0;
            vb_offset  = '0;
            vb_limit   = '0;
            rejected   = 1'b0;
        endfunction

        function len_step_e length_byte(logic [7:0] b);
            int unsigned v;
            if (len_left == 0)
            begin
                if (b[7])
                begin
                    if (b[6:0] == 7'd0)
                        return LEN_BAD;
                    len_left = b[6:0];
                    len_acc  = 0;
                    return LEN_MORE;
                end
                len_acc = b;
                return LEN_DONE;
            end
            v = len_acc * 256 + b;
            if (v > LENGTH_MAX)
                return LEN_BAD;
            len_acc = v;
            len_left--;
            return (len_left == 0) ? LEN_DONE : LEN_MORE;
        endfunction

        function void narrow(int unsigned next_pos, int unsigned len);
            if (next_pos + len < limit)
                limit = next_pos + len;
        endfunction

        function void integer_done(logic [30:0] expected_id);
            case (site)
                SITE_VERSION:
                begin
                    if (int_acc != 64'd0)
                        rejected = 1'b1;
                    else
                        phase = P_COMM_TAG;
                end
                SITE_REQ_ID:
                begin
                    req_id = int_acc[31:0];
                    if (req_id != {1'b0, expected_id})
                        rejected = 1'b1;
                    else
                    begin
                        site  = SITE_STATUS;
                        phase = P_INT_TAG;
                    end
                end
                SITE_STATUS:
                begin
                    err_status = int_acc;
                    site       = SITE_INDEX;
                    phase      = P_INT_TAG;
                end
                default:
                begin
                    err_index = int_acc;
                    phase     = P_VB_TAG;
                end
            endcase
        endfunction

        function void parse_byte(logic [7:0] b, int unsigned pos, logic [30:0] expected_id);
            len_step_e r;
            if (phase == P_DONE)
                return;
            if (pos >= limit)
            begin
                rejected = 1'b1;
                return;
            end
            case (phase)
                P_OUTER_TAG, P_VB_TAG:
                begin
                    if (b != TAG_SEQUENCE)
                    begin
                        rejected = 1'b1;
                        return;
                    end
                    len_left = 0;
                    phase = (phase == P_OUTER_TAG) ? P_OUTER_LEN : P_VB_LEN;
                end
                P_INT_TAG:
                begin
                    if (b != TAG_INTEGER)
                    begin
                        rejected = 1'b1;
                        return;
                    end
                    len_left = 0;
                    phase    = P_INT_LEN;
                end
                P_COMM_TAG:
                begin
                    if (b != TAG_OCTETS)
                    begin
                        rejected = 1'b1;
                        return;
                    end
                    len_left = 0;
                    phase    = P_COMM_LEN;
                end
                P_PDU_TAG:
                begin
                    if (b < TAG_PDU_LO || b > TAG_PDU_HI)
                    begin
                        rejected = 1'b1;
                        return;
                    end
                    pdu_tag  = b;
                    len_left = 0;
                    phase    = P_PDU_LEN;
                end
                P_INT_BODY:
                begin
                    int_acc = {int_acc[55:0], b};
                    int_left--;
                    if (int_left == 0)
                        integer_done(expected_id);
                end
                P_COMM_SKIP:
                begin
                    skip_left--;
                    if (skip_left == 0)
                        phase = P_PDU_TAG;
                end
                default:
                begin
                    r = length_byte(b);
                    if (r == LEN_BAD)
                    begin
                        rejected = 1'b1;
                        return;
                    end
                    if (r == LEN_MORE)
                        return;
                    case (phase)
                        P_OUTER_LEN:
                        begin
                            narrow(pos + 1, len_acc);
                            site  = SITE_VERSION;
                            phase = P_INT_TAG;
                        end
                        P_PDU_LEN:
                        begin
                            narrow(pos + 1, len_acc);
                            site  = SITE_REQ_ID;
                            phase = P_INT_TAG;
                        end
                        P_COMM_LEN:
                        begin
                            comm_len  = len_acc[16:0];
                            skip_left = len_acc;
                            phase = (skip_left == 0) ? P_PDU_TAG : P_COMM_SKIP;
                        end
                        P_INT_LEN:
                        begin
                            if (len_acc > MAX_INTEGER_BYTES)
                            begin
                                rejected = 1'b1;
                                return;
                            end
                            int_acc  = '0;
                            int_left = len_acc;
                            if (int_left == 0)
                                integer_done(expected_id);
                            else
                                phase = P_INT_BODY;
                        end
                        default:
                        begin
                            narrow(pos + 1, len_acc);
                            vb_offset = 16'(pos + 1);
                            vb_limit  = (limit > 32'hFFFF) ? 16'hFFFF : 16'(limit);
                            phase     = P_DONE;
                        end
                    endcase
                end
            endcase
        endfunction

        function void note_word(logic [7:0] b, logic last, logic [30:0] expected_id);
            int unsigned pos;
            result_t     want;
            pos = offset;
            if (pos >= MAX_PACKET_BYTES)
                rejected = 1'b1;
            if (!rejected)
                parse_byte(b, pos, expected_id);
            offset = (pos >= 32'hFFFF) ? 32'hFFFF : pos + 1;
            if (!last)
                return;
            want = '0;
            if (!rejected && phase == P_DONE)
            begin
                want.rsp_id          = req_id;
                want.err_stat        = err_status;
                want.err_idx         = err_index;
                want.comm_bytes      = comm_len;
                want.pdu_type        = pdu_tag;
                want.varbinds_offset = vb_offset;
                want.varbinds_end    = (vb_limit < pos + 1) ? vb_limit : 16'(pos + 1);
            end
            else
                want.verdict = 1'b1;
            verdicts_due.push_back(want);
            restart();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        endtask

        task check_word(result_t got);
            result_t want;
            if (verdicts_due.size() == 0)
            begin
                report_mismatch("verdict word with none expected");
                return;
            end
            want = verdicts_due.pop_front();
            compare_field("verdict", got.verdict, want.verdict);
            compare_field("rsp_id", got.rsp_id, want.rsp_id);
            compare_field("err_stat", got.err_stat, want.err_stat);
            compare_field("err_idx", got.err_idx, want.err_idx);
            compare_field("comm_bytes", got.comm_bytes, want.comm_bytes);
            compare_field("pdu_type", got.pdu_type, want.pdu_type);
            compare_field("varbinds_offset", got.varbinds_offset, want.varbinds_offset);
            compare_field("varbinds_end", got.varbinds_end, want.varbinds_end);
        endtask
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    snmp_header_scoreboard sb = new();

    logic [7:0]  pkt[$];
    logic [30:0] pkt_id;
    bit          hold_req     = 1'b0;
    bit          gaps_on      = 1'b1;
    int unsigned burst_left   = 0;
    int unsigned items_sent   = 0;
    int unsigned packets_sent = 0;

    snmp_response_header_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_word(result_t'({m_tuser, m_tdata[$bits(result_t)-2:0]}));
            if (s_tvalid && s_tready)
                sb.note_word(s_tdata[7:0], s_tlast, s_tdata[38:8]);
        end
    end

    function automatic void put_len(int unsigned n);
        int unsigned nb;
        int unsigned pad;
        nb  = (n > 32'hFFFF) ? 3 : (n > 32'hFF) ? 2 : 1;
        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        if (n < 128 && $urandom_range(0, 3) != 0)
            pkt.push_back(n[7:0]);
        else
        begin
            pkt.push_back(8'h80 | 8'(nb + pad));
            repeat (pad) pkt.push_back(8'h00);
            for (int i = nb - 1; i >= 0; i--)
                pkt.push_back(8'(n >> (8 * i)));
        end
    endfunction

    function automatic logic [31:0] put_int(int unsigned len, int unsigned zeros,
                                            bit keep_b31_low);
        logic [31:0] low;
        logic [7:0]  b;
        low = '0;
        pkt.push_back(TAG_INTEGER);
        put_len(len);
        for (int i = int'(len) - 1; i >= 0; i--)
        begin
            b = (i < zeros) ? 8'h00 : 8'($urandom);
            if (i == 3 && keep_b31_low)
                b[7] = 1'b0;
            low = {low[23:0], b};
            pkt.push_back(b);
        end
        return low;
    endfunction

    function automatic int unsigned pick_int_len();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return 0;
        if (k < 14)
            return $urandom_range(1, 4);
        if (k < 18)
            return $urandom_range(5, MAX_INTEGER_BYTES);
        return $urandom_range(MAX_INTEGER_BYTES + 1, MAX_INTEGER_BYTES + 4);
    endfunction

    function automatic int unsigned skew(int unsigned n);
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k < 15)
            return n;
        if (k < 17)
            return n + $urandom_range(1, 4);
        if (k < 19)
            return (n > 0) ? n - $urandom_range(1, (n < 4) ? n : 4) : 0;
        return ($urandom_range(0, 1) != 0) ? LENGTH_MAX : LENGTH_MAX + $urandom_range(1, 300);
    endfunction

    function automatic void build_response();
        logic [7:0]  part[$];
        logic [31:0] rid;
        int unsigned n;
        pkt.delete();
        rid = put_int(pick_int_len(), 0, $urandom_range(0, 7) != 0);
        void'(put_int(pick_int_len(), ($urandom_range(0, 1) != 0) ? 64 : 0, 1'b0));
        void'(put_int(pick_int_len(), ($urandom_range(0, 1) != 0) ? 64 : 0, 1'b0));
        pkt.push_back(TAG_SEQUENCE);
        n = $urandom_range(0, 8);
        put_len(skew(n));
        repeat (n) pkt.push_back(8'($urandom));
        part = pkt;
        pkt.delete();
        pkt.push_back(TAG_PDU_LO + 8'($urandom_range(0, 5)));
        put_len(skew(part.size()));
        pkt = {pkt, part};
        part = pkt;
        pkt.delete();
        void'(put_int(($urandom_range(0, 9) == 0) ? pick_int_len() : 1,
                      ($urandom_range(0, 7) == 0) ? 0 : 64, 1'b0));
        pkt.push_back(TAG_OCTETS);
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(120, 300) : $urandom_range(0, 8);
        put_len(n);
        repeat (n) pkt.push_back(8'($urandom));
        pkt = {pkt, part};
        part = pkt;
        pkt.delete();
        pkt.push_back(TAG_SEQUENCE);
        put_len(skew(part.size()));
        pkt = {pkt, part};
        if ($urandom_range(0, 7) == 0)
            pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, pkt.size());
            while (pkt.size() > n)
                void'(pkt.pop_back());
        end
        pkt_id = (!rid[31] && $urandom_range(0, 9) != 0) ? rid[30:0] : 31'($urandom);
    endfunction

    function automatic void build_noise(int unsigned max_len);
        int unsigned n;
        pkt.delete();
        n = $urandom_range(1, max_len);
        pkt.push_back(($urandom_range(0, 2) == 0) ? TAG_SEQUENCE : 8'($urandom));
        repeat (n - 1) pkt.push_back(8'($urandom));
        pkt_id = 31'($urandom);
    endfunction

    task automatic idle(int unsigned n);
        if (n == 0)
            return;
        s_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic send_word(logic [7:0] b, logic last, logic [30:0] id);
        if (gaps_on && burst_left == 0)
        begin
            idle($urandom_range(0, 6));
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, id, b};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
            send_word(pkt[i], i == pkt.size() - 1, pkt_id);
        packets_sent++;
    endtask

    task automatic wait_drained();
        idle(1);
        while (sb.verdicts_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : receiver
        int unsigned tick;
        int unsigned mode;
        tick = 0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (tick % 300 == 0)
                    mode = $urandom_range(0, 3);
                tick++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) != 0);
                    2:       m_tready <= (tick % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial
    begin : stimulus
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A wrong opening tag, then a zero length-of-length.
        pkt = '{8'hFF};
        pkt_id = '0;
        send_packet();
        pkt = '{8'h30, 8'h80};
        pkt_id = '1;
        send_packet();
        // Minimal response with the largest request id; its outer and PDU lengths exceed the bytes that follow.
        pkt = '{8'h30, 8'h14, 8'h02, 8'h00, 8'h04, 8'h00, 8'hA0, 8'h0E, 8'h02, 8'h04,
                8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'h02, 8'h00, 8'h30, 8'h00};
        pkt_id = 31'h7FFFFFFF;
        send_packet();

        while (items_sent < 1140 || packets_sent < 70)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0)
                build_noise(6);
            else
                build_response();
            send_packet();
            if (!held && items_sent >= 400)
            begin
                held     = 1'b1;
                hold_req = 1'b1;
                repeat (24)
                begin
                    build_noise(3);
                    send_packet();
                end
            end
            if (!paused && items_sent >= 800)
            begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (sb.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* snmp_response_header_parser.f */
rtl/snmprh_pkg.sv
rtl/snmprh_core.sv
rtl/snmp_response_header_parser.sv
rtl/snmprh_checker.sv
tb/testbench.sv
